@@ sv/erc_pkg.sv @@
// ----------------------------------------------------------------------------
// erc_pkg
// Shared types, constants and modular helpers of the rotor cipher block.
// ----------------------------------------------------------------------------
`default_nettype none

package erc_pkg;

  localparam int LETTER_W   = 5;
  localparam int POS_W      = 5;
  localparam int CHOICE_W   = 3;
  localparam int TSEL_W     = 3;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 5;
  // Wide enough to compare a select or choice against the rotor count + 1.
  localparam int SEL_CMP_W  = 4;

  localparam int DEF_NUM_ROTORS    = 5;
  localparam int DEF_ALPHABET_SIZE = 26;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD    = 2'd0,
    MODE_LETTER  = 2'd1,
    MODE_RESTART = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAST_CHOICE   = 3'd0,
    CFG_MIDDLE_CHOICE = 3'd1,
    CFG_SLOW_CHOICE   = 3'd2,
    CFG_FAST_START    = 3'd3,
    CFG_MIDDLE_START  = 3'd4,
    CFG_SLOW_START    = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_ROTOR     = 2'd0,
    KIND_REFLECTOR = 2'd1,
    KIND_PLUGBOARD = 2'd2,
    KIND_LETTER    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                         kind;
    logic [TSEL_W-1:0]             rotor_sel;
    logic [LETTER_W-1:0]           entry_index;
    logic [LETTER_W-1:0]           entry_value;
    logic [LETTER_W-1:0]           letter;
    logic [2:0][POS_W-1:0]         pos;
    logic [2:0][CHOICE_W-1:0]      choice;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } slot_t;

  // Both operands are below m, so one conditional subtract reduces the sum.
  function automatic logic [LETTER_W-1:0] mod_add(input logic [LETTER_W-1:0] a,
                                                  input logic [LETTER_W-1:0] b,
                                                  input int m);
    logic [LETTER_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (LETTER_W+1)'(m)) s = s - (LETTER_W+1)'(m);
    return s[LETTER_W-1:0];
  endfunction

  function automatic logic [LETTER_W-1:0] mod_sub(input logic [LETTER_W-1:0] a,
                                                  input logic [LETTER_W-1:0] b,
                                                  input int m);
    logic [LETTER_W:0] s;
    s = {1'b0, a} + (LETTER_W+1)'(m) - {1'b0, b};
    if (s >= (LETTER_W+1)'(m)) s = s - (LETTER_W+1)'(m);
    return s[LETTER_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/erc_ram.sv @@
// ----------------------------------------------------------------------------
// erc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module erc_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 26
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/erc_front.sv @@
// ----------------------------------------------------------------------------
// erc_front
// Accepts items, classifies them, owns the rotor positions and the settings.
// ----------------------------------------------------------------------------
`default_nettype none

module erc_front #(
  parameter int NUM_ROTORS    = erc_pkg::DEF_NUM_ROTORS,
  parameter int ALPHABET_SIZE = erc_pkg::DEF_ALPHABET_SIZE
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic [erc_pkg::MODE_W-1:0]    mode,
  input  wire logic [erc_pkg::TSEL_W-1:0]    table_select,
  input  wire logic [erc_pkg::LETTER_W-1:0]  entry_index,
  input  wire logic [erc_pkg::LETTER_W-1:0]  entry_value,
  input  wire logic [erc_pkg::LETTER_W-1:0]  letter,
  input  wire logic                          cfg_we,
  input  wire logic [erc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [erc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                          full,
  output      erc_pkg::slot_t                push
);

  import erc_pkg::*;

  localparam int LUT_N = 1 << LETTER_W;

  logic                accept;
  logic [CHOICE_W-1:0] choice [3];
  logic [POS_W-1:0]    start [3];
  logic [POS_W-1:0]    pos [3];
  logic [POS_W-1:0]    pos_next [3];
  logic [CHOICE_W-1:0] sat_choice [3];
  logic [LETTER_W-1:0] mod_lut [LUT_N];
  logic                load_ok;
  logic                wrap0;
  logic                wrap1;

  // Reduction of any 5-bit value modulo the alphabet size.
  for (genvar i = 0; i < LUT_N; i++) begin : g_lut
    localparam int R = i % ALPHABET_SIZE;
    assign mod_lut[i] = LETTER_W'(R);
  end

  assign in_stall = full;
  assign accept   = in_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      choice[0] <= CHOICE_W'(0);
      choice[1] <= CHOICE_W'(1);
      choice[2] <= CHOICE_W'(2);
      start[0]  <= '0;
      start[1]  <= '0;
      start[2]  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_FAST_CHOICE:   choice[0] <= cfg_data[CHOICE_W-1:0];
        CFG_MIDDLE_CHOICE: choice[1] <= cfg_data[CHOICE_W-1:0];
        CFG_SLOW_CHOICE:   choice[2] <= cfg_data[CHOICE_W-1:0];
        CFG_FAST_START:    start[0]  <= cfg_data[POS_W-1:0];
        CFG_MIDDLE_START:  start[1]  <= cfg_data[POS_W-1:0];
        CFG_SLOW_START:    start[2]  <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sat_choice[i] = ({1'b0, choice[i]} >= SEL_CMP_W'(NUM_ROTORS)) ?
                      CHOICE_W'(NUM_ROTORS - 1) : choice[i];
    end
  end

  // Odometer stepping: fast always, carries ripple on wrap to zero.
  assign wrap0 = (pos[0] == POS_W'(ALPHABET_SIZE - 1));
  assign wrap1 = (pos[1] == POS_W'(ALPHABET_SIZE - 1));

  always_comb begin
    pos_next[0] = wrap0 ? '0 : pos[0] + 1'b1;
    pos_next[1] = pos[1];
    pos_next[2] = pos[2];
    if (wrap0) begin
      pos_next[1] = wrap1 ? '0 : pos[1] + 1'b1;
      if (wrap1) begin
        pos_next[2] = (pos[2] == POS_W'(ALPHABET_SIZE - 1)) ? '0 : pos[2] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos[0] <= '0;
      pos[1] <= '0;
      pos[2] <= '0;
    end else if (accept) begin
      unique case (mode_t'(mode))
        MODE_LETTER: begin
          pos <= pos_next;
        end
        MODE_RESTART: begin
          pos[0] <= mod_lut[start[0]];
          pos[1] <= mod_lut[start[1]];
          pos[2] <= mod_lut[start[2]];
        end
        default: ;
      endcase
    end
  end

  assign load_ok = ({1'b0, entry_index} < (LETTER_W+1)'(ALPHABET_SIZE)) &&
                   ({1'b0, entry_value} < (LETTER_W+1)'(ALPHABET_SIZE));

  always_comb begin
    push.valid            = 1'b0;
    push.item             = '0;
    push.item.rotor_sel   = table_select;
    push.item.entry_index = entry_index;
    push.item.entry_value = entry_value;
    push.item.letter      = mod_lut[letter];
    for (int i = 0; i < 3; i++) begin
      push.item.pos[i]    = pos[i];
      push.item.choice[i] = sat_choice[i];
    end
    unique case (mode_t'(mode))
      MODE_LOAD: begin
        priority if (!load_ok) begin
          push.valid = 1'b0;
        end else if ({1'b0, table_select} < SEL_CMP_W'(NUM_ROTORS)) begin
          push.valid     = 1'b1;
          push.item.kind = KIND_ROTOR;
        end else if ({1'b0, table_select} == SEL_CMP_W'(NUM_ROTORS)) begin
          push.valid     = 1'b1;
          push.item.kind = KIND_REFLECTOR;
        end else if ({1'b0, table_select} == SEL_CMP_W'(NUM_ROTORS + 1)) begin
          push.valid     = 1'b1;
          push.item.kind = KIND_PLUGBOARD;
        end else begin
          push.valid = 1'b0;
        end
      end
      MODE_LETTER: begin
        push.valid     = 1'b1;
        push.item.kind = KIND_LETTER;
      end
      default: ;
    endcase
    push.valid = push.valid && accept;
  end

  a_letter_pushed: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == MODE_LETTER) |-> push.valid)
    else $error("accepted letter item was not queued");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !full)
    else $error("item pushed into a full queue");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, pos[0]} < (POS_W+1)'(ALPHABET_SIZE)) &&
    ({1'b0, pos[1]} < (POS_W+1)'(ALPHABET_SIZE)) &&
    ({1'b0, pos[2]} < (POS_W+1)'(ALPHABET_SIZE)))
    else $error("rotor position outside the alphabet");

endmodule

`default_nettype wire

@@ sv/erc_queue.sv @@
// ----------------------------------------------------------------------------
// erc_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module erc_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire erc_pkg::slot_t push,
  output      logic           full,
  output      erc_pkg::slot_t head,
  input  wire logic           pop
);

  import erc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t              mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) mem[wr_ptr] <= push.item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push.valid, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("pop from an empty queue");

  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    (push.valid && !pop) |=> (count == CNT_W'($past(count) + 1'b1)))
    else $error("queue count did not follow a push");

endmodule

`default_nettype wire

@@ sv/erc_back.sv @@
// ----------------------------------------------------------------------------
// erc_back
// Nine-lookup pipeline: plugboard, three rotors, reflector, three inverse
// rotors, plugboard. Each stage owns its table copy and applies table loads.
// ----------------------------------------------------------------------------
`default_nettype none

module erc_back #(
  parameter int NUM_ROTORS    = erc_pkg::DEF_NUM_ROTORS,
  parameter int ALPHABET_SIZE = erc_pkg::DEF_ALPHABET_SIZE
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire erc_pkg::slot_t               head,
  output      logic                         pop,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic [erc_pkg::LETTER_W-1:0] cipher_letter
);

  import erc_pkg::*;

  localparam int ROT_DEPTH = NUM_ROTORS * ALPHABET_SIZE;
  localparam int ROT_AW    = $clog2(ROT_DEPTH);
  localparam int ALPHA_AW  = $clog2(ALPHABET_SIZE);

  logic                adv;
  logic [9:1]          v_q;
  item_t               it_q [1:9];
  logic [LETTER_W-1:0] rd [9];

  // The whole pipeline holds while a finished letter waits at the output.
  assign out_valid     = v_q[9] && (it_q[9].kind == KIND_LETTER);
  assign adv           = !(out_valid && out_stall);
  assign pop           = adv && head.valid;
  assign cipher_letter = rd[8];

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[8:1], head.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it_q[1] <= head.item;
      for (int k = 2; k <= 9; k++) it_q[k] <= it_q[k-1];
    end
  end

  // Entry plugboard.
  erc_ram #(.WIDTH(LETTER_W), .DEPTH(ALPHABET_SIZE)) u_plug_in (
    .clk   (clk),
    .we    (adv && head.valid && (head.item.kind == KIND_PLUGBOARD)),
    .waddr (ALPHA_AW'(head.item.entry_index)),
    .wdata (head.item.entry_value),
    .re    (adv),
    .raddr (ALPHA_AW'(head.item.letter)),
    .rdata (rd[0])
  );

  // Rotor stages 1-3 run forward (fast, middle, slow), 5-7 inverse (slow,
  // middle, fast). A stage after a rotor first removes that rotor's offset.
  for (genvar k = 1; k < 8; k++) begin : g_rot
    if (k != 4) begin : g_stage
      localparam bit INV   = (k >= 5);
      localparam int R     = INV ? (7 - k) : (k - 1);
      localparam bit FIRST = (k == 1) || (k == 5);
      localparam int PREV  = FIRST ? 0 : (INV ? (8 - k) : (k - 2));

      logic [LETTER_W-1:0] c_in;
      logic [LETTER_W-1:0] x;
      logic [ROT_AW-1:0]   base_rd;
      logic [ROT_AW-1:0]   base_wr;
      logic [ROT_AW-1:0]   waddr;
      logic [LETTER_W-1:0] wdata;

      assign c_in    = FIRST ? rd[k-1] :
                       mod_sub(rd[k-1], it_q[k].pos[PREV], ALPHABET_SIZE);
      assign x       = mod_add(c_in, it_q[k].pos[R], ALPHABET_SIZE);
      assign base_rd = ROT_AW'(it_q[k].choice[R]) * ROT_AW'(ALPHABET_SIZE);
      assign base_wr = ROT_AW'(it_q[k].rotor_sel) * ROT_AW'(ALPHABET_SIZE);
      // The inverse table stores the entry index under the wired value.
      assign waddr   = base_wr + ROT_AW'(INV ? it_q[k].entry_value : it_q[k].entry_index);
      assign wdata   = INV ? it_q[k].entry_index : it_q[k].entry_value;

      erc_ram #(.WIDTH(LETTER_W), .DEPTH(ROT_DEPTH)) u_rotor (
        .clk   (clk),
        .we    (adv && v_q[k] && (it_q[k].kind == KIND_ROTOR)),
        .waddr (waddr),
        .wdata (wdata),
        .re    (adv),
        .raddr (base_rd + ROT_AW'(x)),
        .rdata (rd[k])
      );
    end
  end

  erc_ram #(.WIDTH(LETTER_W), .DEPTH(ALPHABET_SIZE)) u_reflector (
    .clk   (clk),
    .we    (adv && v_q[4] && (it_q[4].kind == KIND_REFLECTOR)),
    .waddr (ALPHA_AW'(it_q[4].entry_index)),
    .wdata (it_q[4].entry_value),
    .re    (adv),
    .raddr (ALPHA_AW'(mod_sub(rd[3], it_q[4].pos[2], ALPHABET_SIZE))),
    .rdata (rd[4])
  );

  // Exit plugboard, a second copy kept in step with the entry one.
  erc_ram #(.WIDTH(LETTER_W), .DEPTH(ALPHABET_SIZE)) u_plug_out (
    .clk   (clk),
    .we    (adv && v_q[8] && (it_q[8].kind == KIND_PLUGBOARD)),
    .waddr (ALPHA_AW'(it_q[8].entry_index)),
    .wdata (it_q[8].entry_value),
    .re    (adv),
    .raddr (ALPHA_AW'(mod_sub(rd[7], it_q[8].pos[0], ALPHABET_SIZE))),
    .rdata (rd[8])
  );

  a_hold_no_pop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !pop)
    else $error("queue drained while the output is held");

  a_pop_has_item: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop without a queued item");

  a_frozen_stages: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(v_q))
    else $error("pipeline moved while held");

endmodule

`default_nettype wire

@@ sv/enigma_rotor_cipher.sv @@
// ----------------------------------------------------------------------------
// enigma_rotor_cipher
// Three-rotor rotor-machine cipher with loadable wirings, reflector and
// plugboard; one letter per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one item per cycle: a table
//   load (mode 0), a letter to encipher (mode 1) or a restart of the rotor
//   positions from the start registers (mode 2). Only letters give a result
//   item on the output channel (out_valid / out_stall, cipher_letter).
//   The settings port (cfg_we, cfg_index, cfg_data) writes the rotor choices
//   and start positions; write it only while no item is in flight.
//   An accepted item is written into the queue, then passes the pipeline
//   stages to out_valid. Throughput is one item per cycle while the output
//   is not stalled, set by the nine-stage lookup pipeline with one table
//   read per stage.
//   A 4-entry queue sits between the classifier and the pipeline, so input
//   items are still taken while the output is stalled until the queue fills;
//   then in_stall rises. A stalled result holds its value.
//   Reset clears the rotor positions, restores the default settings and
//   empties the queue and pipeline; the tables hold nothing defined until
//   loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module enigma_rotor_cipher #(
  parameter int NUM_ROTORS    = erc_pkg::DEF_NUM_ROTORS,
  parameter int ALPHABET_SIZE = erc_pkg::DEF_ALPHABET_SIZE
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire logic [erc_pkg::MODE_W-1:0]     mode,
  input  wire logic [erc_pkg::TSEL_W-1:0]     table_select,
  input  wire logic [erc_pkg::LETTER_W-1:0]   entry_index,
  input  wire logic [erc_pkg::LETTER_W-1:0]   entry_value,
  input  wire logic [erc_pkg::LETTER_W-1:0]   letter,
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      logic [erc_pkg::LETTER_W-1:0]   cipher_letter,
  input  wire logic                           cfg_we,
  input  wire logic [erc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [erc_pkg::CFG_DATA_W-1:0] cfg_data
);

  import erc_pkg::*;

  slot_t push;
  slot_t head;
  logic  full;
  logic  pop;

  erc_front #(.NUM_ROTORS(NUM_ROTORS), .ALPHABET_SIZE(ALPHABET_SIZE)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .table_select (table_select),
    .entry_index  (entry_index),
    .entry_value  (entry_value),
    .letter       (letter),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .full         (full),
    .push         (push)
  );

  erc_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .head (head),
    .pop  (pop)
  );

  erc_back #(.NUM_ROTORS(NUM_ROTORS), .ALPHABET_SIZE(ALPHABET_SIZE)) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cipher_letter (cipher_letter)
  );

endmodule

`default_nettype wire
